>>> sv/sorted_table_binary_search_defines.svh
// ----------------------------------------------------------------------------
// Sorted table binary search: assertion macros
// Shared helpers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define STBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define STBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/stbs_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table binary search: package
// Beat layouts, command codes, controller states and the control/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package stbs_pkg;

    // Field widths
    localparam int POS_W = 5;
    localparam int VAL_W = 32;

    // Input beat layout (s_tdata), lowest bit first
    localparam int S_IDX_LSB  = 0;
    localparam int S_VAL_LSB  = S_IDX_LSB + POS_W;
    localparam int S_KEY_LSB  = S_VAL_LSB + VAL_W;
    localparam int S_LOW_LSB  = S_KEY_LSB + VAL_W;
    localparam int S_HIGH_LSB = S_LOW_LSB + POS_W;
    localparam int S_USED_W   = S_HIGH_LSB + POS_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;

    // Output beat layout (m_tdata)
    localparam int M_TDATA_W  = ((POS_W + 7) / 8) * 8;

    // Command carried in s_tuser
    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_code_t;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic wr_en;   // store one table entry
        logic load;    // start a search: latch key and range
        logic step;    // narrow the range after a miss
        logic emit;    // load the result register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic range_empty;  // low has passed high
        logic hit;          // probed entry equals the key
        logic out_free;     // result register can take a beat this cycle
    } dp_status_t;

endpackage

>>> sv/stbs_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted table binary search: controller
// Two-state sequencer. Takes write beats at once, runs one search at a time
// and hands its result to the datapath's output register.
// ----------------------------------------------------------------------------
module stbs_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_cmd,
    output logic                in_ready,
    input  stbs_pkg::dp_status_t status,
    output stbs_pkg::dp_cmd_t    cmd
);
    import stbs_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_cmd == CMD_SEARCH)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (status.range_empty || status.hit)
                begin
                    // finish only when the result register can take the beat
                    if (status.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/stbs_dp.sv
// ----------------------------------------------------------------------------
// Sorted table binary search: datapath
// Table memory, search bounds, probe compare and the result register.
// The read address follows the bounds being loaded, so the registered read
// data belongs to the midpoint of the current bounds while the range is not empty.
// ----------------------------------------------------------------------------
module stbs_dp
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  stbs_pkg::dp_cmd_t                    cmd,
    output stbs_pkg::dp_status_t                 status,
    input  logic [stbs_pkg::POS_W-1:0]           entry_index,
    input  logic signed [stbs_pkg::VAL_W-1:0]    entry_value,
    input  logic signed [stbs_pkg::VAL_W-1:0]    search_key,
    input  logic [stbs_pkg::POS_W-1:0]           range_low,
    input  logic [stbs_pkg::POS_W-1:0]           range_high,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic                                 found,
    output logic [stbs_pkg::POS_W-1:0]           match_position
);
    import stbs_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    // bound width: room for every index, one past the top and minus one
    localparam int XW = ((AW > POS_W) ? AW : POS_W) + 2;
    localparam logic signed [XW-1:0] TOP_IDX = XW'(TABLE_DEPTH - 1);
    localparam logic signed [XW-1:0] DEPTH_X = XW'(TABLE_DEPTH);

    logic signed [VAL_W-1:0] mem [TABLE_DEPTH];
    logic signed [VAL_W-1:0] rd_data_reg;
    logic signed [VAL_W-1:0] key_reg;
    logic signed [XW-1:0]    lo_reg;
    logic signed [XW-1:0]    hi_reg;
    logic signed [XW-1:0]    lo_next;
    logic signed [XW-1:0]    hi_next;
    logic signed [XW:0]      sum_cur;
    logic signed [XW:0]      sum_next;
    logic signed [XW-1:0]    mid_cur;
    logic signed [XW-1:0]    mid_next;
    logic signed [XW-1:0]    low_ext;
    logic signed [XW-1:0]    high_ext;
    logic signed [XW-1:0]    widx_ext;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic                    wr_ok;
    logic                    entry_less;
    logic                    out_valid_reg;
    logic                    found_reg;
    logic [POS_W-1:0]        pos_reg;

    // Widen the 5-bit indices
    assign low_ext  = signed'({{(XW-POS_W){1'b0}}, range_low});
    assign high_ext = signed'({{(XW-POS_W){1'b0}}, range_high});
    assign widx_ext = signed'({{(XW-POS_W){1'b0}}, entry_index});

    // Midpoint of the current bounds
    assign sum_cur = XW'(lo_reg) + XW'(hi_reg) + (XW+1)'(0);
    assign mid_cur = sum_cur[XW:1];

    // Probe compare
    assign entry_less = rd_data_reg < key_reg;

    assign status.range_empty = lo_reg > hi_reg;
    assign status.hit         = !(lo_reg > hi_reg) && (rd_data_reg == key_reg);
    assign status.out_free    = !out_valid_reg || out_ready;

    // Next bounds: load a new range or narrow after a miss
    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.load)
        begin
            lo_next = low_ext;
            hi_next = (high_ext > TOP_IDX) ? TOP_IDX : high_ext;
        end
        else if (cmd.step)
        begin
            if (entry_less)
            begin
                lo_next = mid_cur + XW'(1);
            end
            else
            begin
                hi_next = mid_cur - XW'(1);
            end
        end
    end

    // Read address tracks the bounds about to be registered
    assign sum_next = {lo_next[XW-1], lo_next} + {hi_next[XW-1], hi_next};
    assign mid_next = sum_next[XW:1];
    assign rd_addr  = mid_next[AW-1:0];

    // Drop writes past the end of the table
    assign wr_ok   = widx_ext < DEPTH_X;
    assign wr_addr = widx_ext[AW-1:0];

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_ok)
        begin
            mem[wr_addr] <= entry_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Search bounds and key
    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (cmd.load)
        begin
            key_reg <= search_key;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            found_reg <= status.hit;
            pos_reg   <= status.hit ? mid_cur[POS_W-1:0] : '0;
        end
    end

    // Result valid: set on emit, clear when the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign match_position = pos_reg;

endmodule

>>> sv/sorted_table_binary_search.sv
// Operation: a write beat is taken while idle; a search is accepted, then probes one
//   table entry per cycle, at most clog2(TABLE_DEPTH)+1 probes (6 for 32); on a hit
//   or once the range runs empty, its result is registered when the output is free.
// Throughput: write beats every cycle while idle; no new beat is taken until the
//   running search has handed its result to the result register.
// Reset: control state and result valid clear; table contents stay undefined.
// ----------------------------------------------------------------------------
// Sorted table binary search: top level
// Stream wrapper around the search controller and datapath.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_defines.svh"

module sorted_table_binary_search
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // entry_index, entry_value, search_key, range_low, range_high, zero pad
    input  logic [stbs_pkg::S_TDATA_W-1:0]    s_tdata,
    // cmd
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // match_position, zero pad
    output logic [stbs_pkg::M_TDATA_W-1:0]    m_tdata,
    // found
    output logic                              m_tuser
);
    import stbs_pkg::*;

    dp_cmd_t           ctl_cmd;
    dp_status_t        dp_status;
    logic [POS_W-1:0]  match_position;
    logic              found;

    // Controller
    stbs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser),
        .in_ready (s_tready),
        .status   (dp_status),
        .cmd      (ctl_cmd)
    );

    // Datapath
    stbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (ctl_cmd),
        .status         (dp_status),
        .entry_index    (s_tdata[S_IDX_LSB +: POS_W]),
        .entry_value    (signed'(s_tdata[S_VAL_LSB +: VAL_W])),
        .search_key     (signed'(s_tdata[S_KEY_LSB +: VAL_W])),
        .range_low      (s_tdata[S_LOW_LSB +: POS_W]),
        .range_high     (s_tdata[S_HIGH_LSB +: POS_W]),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .found          (found),
        .match_position (match_position)
    );

    // Pack the result beat
    assign m_tdata = {{(M_TDATA_W-POS_W){1'b0}}, match_position};
    assign m_tuser = found;

    // Checks
    `STBS_ASSERT_NOW(a_emit_free, ctl_cmd.emit, (!m_tvalid || m_tready), "result overwritten")
    `STBS_ASSERT_NEXT(a_busy_after_load, ctl_cmd.load, !s_tready, "input taken during search")
    `STBS_ASSERT_NOW(a_miss_pos_zero, (m_tvalid && !m_tuser), (m_tdata == '0), "miss with position")
    `STBS_ASSERT_NOW(a_one_action, 1'b1, $onehot0(ctl_cmd), "conflicting datapath commands")

endmodule
